// ----- hdl/assert_macros.svh -----
// Assertion macros used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is asserted.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ----- hdl/csrsq_pkg.sv -----
// Types and constants of the cyclic shift range sum query unit.
`default_nettype none

package csrsq_pkg;

  // Fixed field widths
  localparam int unsigned LEN_W    = 11;
  localparam int unsigned ELEM_W   = 20;
  localparam int unsigned POS_W    = 21;
  localparam int unsigned SUM_W    = 48;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned CNT_W    = $clog2(POS_W);

  // Operation codes
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_BAD_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NOT_FULL  = 2'd2;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_DIV,
    S_RDA,
    S_RDB,
    S_MUL,
    S_ACC,
    S_OUT
  } csrsq_state_e;

  typedef struct packed {
    logic              op;
    logic [ELEM_W-1:0] element;
    logic [POS_W-1:0]  range_start;
    logic [POS_W-1:0]  range_end;
  } csrsq_in_t;

  typedef struct packed {
    logic [SUM_W-1:0]    range_sum;
    logic [STATUS_W-1:0] status;
  } csrsq_out_t;

endpackage

`default_nettype wire

// ----- hdl/cyclic_shift_range_sum_query_unit.sv -----
// Load: one prefix-table write while the table is not full, a transfer in every cycle while
// no query is in work; no result transfer. Query: a check state, then two passes of a
// restoring divider by n, each followed by two table reads, a multiply and an add; a flagged
// query goes from the check straight to the result. One item is in work at a time: the input
// stays stalled until the result is taken. Reset: fill count 0, length 1, running sum 0;
// the prefix table is not cleared (entries are only read after all n have been written).
`default_nettype none
`include "assert_macros.svh"

module cyclic_shift_range_sum_query_unit #(
  parameter int unsigned MAX_LEN      = 1024,
  parameter int unsigned ELEMENT_BITS = 20
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  csrsq_pkg::csrsq_in_t            in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output csrsq_pkg::csrsq_out_t           out_data_o,
  input  logic                            cfg_we_i,
  input  logic [csrsq_pkg::LEN_W-1:0]     cfg_data_i
);
  import csrsq_pkg::*;

  localparam int unsigned AW     = $clog2(MAX_LEN);
  localparam int unsigned NW     = $clog2(MAX_LEN + 1);
  localparam int unsigned PSUM_W = ELEMENT_BITS + $clog2(MAX_LEN) + 1;
  localparam int unsigned CMP_W  = 2 * NW + POS_W;
  localparam int unsigned PROD_W = NW + PSUM_W;
  localparam logic [PSUM_W-1:0] ELEM_MASK = PSUM_W'((64'd1 << ELEMENT_BITS) - 64'd1);

  // Control registers
  csrsq_state_e        state_q, state_d;
  logic [LEN_W-1:0]    len_q, len_d;
  logic [NW-1:0]       fill_q, fill_d;
  logic [PSUM_W-1:0]   last_sum_q, last_sum_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic                pass_q, pass_d;

  // Datapath registers
  logic [POS_W-1:0]    l_q, l_d, r_q, r_d;
  logic [POS_W-1:0]    quo_q, quo_d;
  logic [NW-1:0]       rem_q, rem_d;
  logic [NW:0]         idxb_q, idxb_d;
  logic                wrap_q, wrap_d;
  logic [PSUM_W-1:0]   a_q, a_d;
  logic [PSUM_W-1:0]   shp_q, shp_d;
  logic [SUM_W-1:0]    prod_q, prod_d;
  logic [SUM_W-1:0]    fr_q, fr_d;
  csrsq_out_t          res_q, res_d;

  // Prefix table
  logic [PSUM_W-1:0]   mem_q [MAX_LEN];
  logic [PSUM_W-1:0]   rd_data_q;
  logic [AW-1:0]       rd_addr;
  logic                mem_we;

  // Misc combinational
  logic [NW-1:0]       n_eff;
  logic [2*NW-1:0]     nsq;
  logic                acc_in;
  logic                table_full;
  logic [PSUM_W-1:0]   sum_new;
  logic [NW-1:0]       x;
  logic [NW:0]         trial;
  logic [PSUM_W-1:0]   b_val;
  logic [PROD_W-1:0]   prod_full;
  logic [SUM_W-1:0]    f_val;

  // Effective length: zero reads as one, clipped to the table depth
  always_comb begin
    if (len_q == '0) begin
      n_eff = NW'(1);
    end else if (32'(len_q) > 32'(MAX_LEN)) begin
      n_eff = NW'(MAX_LEN);
    end else begin
      n_eff = NW'(len_q);
    end
  end

  assign nsq        = {{NW{1'b0}}, n_eff} * {{NW{1'b0}}, n_eff};
  assign table_full = (fill_q >= n_eff);
  assign in_stall_o = (state_q != S_IDLE);
  assign acc_in     = in_valid_i && !in_stall_o;
  assign sum_new    = last_sum_q + (PSUM_W'(in_data_i.element) & ELEM_MASK);
  assign mem_we     = acc_in && (in_data_i.op == OP_LOAD) && !table_full;

  // Quotient of the current pass (at most n for an accepted range)
  assign x         = NW'(quo_q);
  assign trial     = {rem_q, quo_q[POS_W-1]};
  assign b_val     = (idxb_q == '0) ? '0 : rd_data_q;
  assign prod_full = {{PSUM_W{1'b0}}, x} * {{NW{1'b0}}, last_sum_q};
  assign f_val     = prod_q + SUM_W'(shp_q);

  assign out_valid_o = (state_q == S_OUT);
  assign out_data_o  = res_q;

  // Sequencer: next state, datapath and table read address
  always_comb begin
    state_d    = state_q;
    len_d      = len_q;
    fill_d     = fill_q;
    last_sum_d = last_sum_q;
    cnt_d      = cnt_q;
    pass_d     = pass_q;
    l_d        = l_q;
    r_d        = r_q;
    quo_d      = quo_q;
    rem_d      = rem_q;
    idxb_d     = idxb_q;
    wrap_d     = wrap_q;
    a_d        = a_q;
    shp_d      = shp_q;
    prod_d     = prod_q;
    fr_d       = fr_q;
    res_d      = res_q;
    rd_addr    = '0;

    unique case (state_q)
      S_IDLE: begin
        if (acc_in) begin
          if (in_data_i.op == OP_LOAD) begin
            if (!table_full) begin
              fill_d     = fill_q + NW'(1);
              last_sum_d = sum_new;
            end
          end else begin
            l_d     = in_data_i.range_start;
            r_d     = in_data_i.range_end;
            state_d = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        if (!table_full) begin
          res_d   = '{range_sum: '0, status: STATUS_NOT_FULL};
          state_d = S_OUT;
        end else if (l_q == '0 || l_q > r_q || CMP_W'(r_q) > CMP_W'(nsq)) begin
          res_d   = '{range_sum: '0, status: STATUS_BAD_RANGE};
          state_d = S_OUT;
        end else begin
          pass_d  = 1'b0;
          quo_d   = r_q;
          rem_d   = '0;
          cnt_d   = '0;
          state_d = S_DIV;
        end
      end
      // One restoring step per cycle: quotient shifts in behind the dividend
      S_DIV: begin
        if (trial >= {1'b0, n_eff}) begin
          rem_d = NW'(trial - {1'b0, n_eff});
          quo_d = {quo_q[POS_W-2:0], 1'b1};
        end else begin
          rem_d = NW'(trial);
          quo_d = {quo_q[POS_W-2:0], 1'b0};
        end
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(POS_W - 1)) begin
          state_d = S_RDA;
        end
      end
      // Read psum(x); pick the end point of the wrapped prefix
      S_RDA: begin
        rd_addr = AW'(x - NW'(1));
        wrap_d  = (rem_q > (n_eff - x));
        if (rem_q > (n_eff - x)) begin
          idxb_d = {1'b0, rem_q} + {1'b0, x} - {1'b0, n_eff};
        end else begin
          idxb_d = {1'b0, rem_q} + {1'b0, x};
        end
        state_d = S_RDB;
      end
      S_RDB: begin
        rd_addr = AW'(idxb_q - (NW + 1)'(1));
        a_d     = (x == '0) ? '0 : rd_data_q;
        state_d = S_MUL;
      end
      // Whole shifts times the total, plus the partial shift
      S_MUL: begin
        if (wrap_q) begin
          shp_d = last_sum_q - a_q + b_val;
        end else begin
          shp_d = b_val - a_q;
        end
        prod_d  = SUM_W'(prod_full);
        state_d = S_ACC;
      end
      S_ACC: begin
        if (!pass_q) begin
          fr_d    = f_val;
          pass_d  = 1'b1;
          quo_d   = l_q - POS_W'(1);
          rem_d   = '0;
          cnt_d   = '0;
          state_d = S_DIV;
        end else begin
          res_d   = '{range_sum: fr_q - f_val, status: STATUS_OK};
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_stall_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // Length write restarts loading
    if (cfg_we_i) begin
      len_d      = cfg_data_i;
      fill_d     = '0;
      last_sum_d = '0;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      len_q      <= LEN_W'(1);
      fill_q     <= '0;
      last_sum_q <= '0;
      cnt_q      <= '0;
      pass_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      len_q      <= len_d;
      fill_q     <= fill_d;
      last_sum_q <= last_sum_d;
      cnt_q      <= cnt_d;
      pass_q     <= pass_d;
    end
  end

  // Datapath registers, no reset
  always_ff @(posedge clk_i) begin
    l_q    <= l_d;
    r_q    <= r_d;
    quo_q  <= quo_d;
    rem_q  <= rem_d;
    idxb_q <= idxb_d;
    wrap_q <= wrap_d;
    a_q    <= a_d;
    shp_q  <= shp_d;
    prod_q <= prod_d;
    fr_q   <= fr_d;
    res_q  <= res_d;
  end

  // Prefix table: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[AW'(fill_q)] <= sum_new;
    end
    rd_data_q <= mem_q[rd_addr];
  end

  // Checks
  `ASSERT_CLK(a_fill_bound, fill_q <= n_eff, "fill count beyond array length")
  `ASSERT_ALWAYS(a_out_blocks_in, out_valid_o |-> in_stall_o, "input open while result held")
  `ASSERT_CLK(a_div_count, (state_q == S_DIV) |-> (cnt_q < CNT_W'(POS_W)), "divider overrun")
  `ASSERT_CLK(a_result_src,
    $rose(out_valid_o) |-> ($past(state_q) == S_ACC || $past(state_q) == S_CHECK),
    "result from unexpected state")

endmodule

`default_nettype wire
